/* rtl/sbf_pkg.sv */
// Package for the sample block framer: request codes, register indexes,
// header word indexes, controller-to-datapath command types.
// No dependencies.
`default_nettype none
package sbf_pkg;

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_SESSION = 2'd1,
		REQ_DISCARD = 2'd2,
		REQ_STATUS  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_SOURCE_ID = 3'd0,
		REG_RATE      = 3'd1,
		REG_MAGIC     = 3'd2,
		REG_VERSION   = 3'd3,
		REG_FLAG_MASK = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		HW_MAGIC    = 3'd0,
		HW_SOURCE   = 3'd1,
		HW_BLOCK_NO = 3'd2,
		HW_FIRST_SQ = 3'd3,
		HW_TIME_LO  = 3'd4,
		HW_TIME_HI  = 3'd5,
		HW_RATE_LEN = 3'd6,
		HW_DROPPED  = 3'd7
	} hdr_word_t;

	typedef enum logic [1:0] {
		SRC_HDR  = 2'd0,
		SRC_DATA = 2'd1,
		SRC_STAT = 2'd2
	} src_t;

	localparam int unsigned HEADER_BYTES = 32;
	localparam logic [15:0] GAP_MAX     = 16'hffff;
	localparam logic        KIND_BLOCK  = 1'b0;
	localparam logic        KIND_STATUS = 1'b1;

	typedef struct packed {
		logic      accept;
		logic      load;
		src_t      src;
		hdr_word_t hdr_word;
		logic      last;
		logic      finish;
	} sbf_ctl_t;

	typedef struct packed {
		logic query;
		logic full;
	} sbf_stat_t;

endpackage
`default_nettype wire

/* rtl/sbf_if.sv */
// Handshake interfaces for the sample block framer: request items in,
// block and status words out. No dependencies.
`default_nettype none
interface sbf_item_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  req_type;
	logic signed [31:0] sample_value;
	logic        [31:0] sample_seq;
	logic        [63:0] timestamp_ns;

	modport source (output valid, req_type, sample_value, sample_seq, timestamp_ns,
		input ready);
	modport sink (input valid, req_type, sample_value, sample_seq, timestamp_ns,
		output ready);
endinterface

interface sbf_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic        last_word;
	logic        result_kind;
	logic [31:0] blocks_produced;
	logic [31:0] blocks_discarded;

	modport source (output valid, out_word, last_word, result_kind, blocks_produced,
		blocks_discarded, input ready);
	modport sink (input valid, out_word, last_word, result_kind, blocks_produced,
		blocks_discarded, output ready);
endinterface
`default_nettype wire

/* rtl/sample_block_framer.sv */
// A sample, session or discard item is taken whenever the block is idle, and a status
// query is accepted, then its answer is loaded into the output register. The sample
// that fills a block holds off further items while 8 header words and the N sample words
// (N alternating BASE_BLOCK_LEN and BASE_BLOCK_LEN+1) go out one per cycle, as long as
// the word sink does not stall. The word rate is set by the single read port of the
// sample store; its registered read is hidden behind the header words. The output
// register lets an item be accepted while a word still waits.
// Top level; uses sbf_pkg, sbf_if, sbf_ctrl and sbf_dp.
`default_nettype none
module sample_block_framer
	import sbf_pkg::*;
#(
	parameter int unsigned BASE_BLOCK_LEN = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata,
	sbf_item_if.sink         items,
	sbf_word_if.source       words
);

	localparam int unsigned AW = $clog2(BASE_BLOCK_LEN + 1);
	localparam int unsigned CW = $clog2(BASE_BLOCK_LEN + 2);

	sbf_ctl_t      ctl;
	sbf_stat_t     st;
	logic [CW-1:0] tgt_len;
	logic [AW-1:0] rd_addr;

	sbf_ctrl #(
		.AW (AW),
		.CW (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (words.valid),
		.out_ready (words.ready),
		.st        (st),
		.tgt_len   (tgt_len),
		.ctl       (ctl),
		.rd_addr   (rd_addr)
	);

	sbf_dp #(
		.BASE_BLOCK_LEN (BASE_BLOCK_LEN),
		.AW             (AW),
		.CW             (CW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.req_type         (items.req_type),
		.sample_value     (items.sample_value),
		.sample_seq       (items.sample_seq),
		.timestamp_ns     (items.timestamp_ns),
		.ctl              (ctl),
		.rd_addr          (rd_addr),
		.st               (st),
		.tgt_len          (tgt_len),
		.out_word         (words.out_word),
		.last_word        (words.last_word),
		.result_kind      (words.result_kind),
		.blocks_produced  (words.blocks_produced),
		.blocks_discarded (words.blocks_discarded)
	);

endmodule
`default_nettype wire

/* rtl/sbf_ctrl.sv */
// Controller of the sample block framer: accepts items, sequences header,
// sample and status words into the output register. Uses sbf_pkg.
`default_nettype none
module sbf_ctrl
	import sbf_pkg::*;
#(
	parameter int unsigned AW = 6,
	parameter int unsigned CW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sbf_stat_t     st,
	input  wire logic [CW-1:0] tgt_len,
	output sbf_ctl_t           ctl,
	output logic      [AW-1:0] rd_addr
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR,
		S_DATA,
		S_STAT
	} state_t;

	state_t        state_q;
	logic          out_vld_q;
	hdr_word_t     hdr_q;
	logic [AW-1:0] dat_q;
	logic          slot_free;
	logic          is_last;

	assign slot_free = !out_vld_q || out_ready;
	assign is_last   = (CW'(dat_q) + CW'(1)) == tgt_len;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		ctl.accept   = in_ready && in_valid;
		ctl.load     = slot_free && (state_q != S_IDLE);
		ctl.hdr_word = hdr_q;
		ctl.last     = 1'b0;
		ctl.src      = SRC_HDR;
		case (state_q)
			S_DATA: begin
				ctl.src  = SRC_DATA;
				ctl.last = is_last;
			end
			S_STAT: begin
				ctl.src  = SRC_STAT;
				ctl.last = 1'b1;
			end
			default: begin
				ctl.src = SRC_HDR;
			end
		endcase
		ctl.finish = ctl.load && (state_q == S_DATA) && is_last;
		if (state_q == S_DATA) begin
			rd_addr = ctl.load ? dat_q + AW'(1) : dat_q;
		end else begin
			rd_addr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			hdr_q     <= HW_MAGIC;
			dat_q     <= '0;
		end else begin
			if (ctl.load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ctl.accept) begin
						if (st.query) begin
							state_q <= S_STAT;
						end else if (st.full) begin
							state_q <= S_HDR;
							hdr_q   <= HW_MAGIC;
						end
					end
				end
				S_HDR: begin
					if (ctl.load) begin
						if (hdr_q == HW_DROPPED) begin
							state_q <= S_DATA;
							dat_q   <= '0;
						end else begin
							hdr_q <= hdr_word_t'(hdr_q + 3'd1);
						end
					end
				end
				S_DATA: begin
					if (ctl.load) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							dat_q <= dat_q + AW'(1);
						end
					end
				end
				S_STAT: begin
					if (ctl.load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/sbf_dp.sv */
// Datapath of the sample block framer: configuration registers, block
// state, sample store, header assembly and output word register. Uses sbf_pkg.
`default_nettype none
module sbf_dp
	import sbf_pkg::*;
#(
	parameter int unsigned BASE_BLOCK_LEN = 32,
	parameter int unsigned AW = 6,
	parameter int unsigned CW = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [2:0]  cfg_idx,
	input  wire logic        [31:0] cfg_wdata,
	input  wire logic        [1:0]  req_type,
	input  wire logic signed [31:0] sample_value,
	input  wire logic        [31:0] sample_seq,
	input  wire logic        [63:0] timestamp_ns,
	input  wire sbf_ctl_t           ctl,
	input  wire logic        [AW-1:0] rd_addr,
	output sbf_stat_t               st,
	output logic             [CW-1:0] tgt_len,
	output logic             [31:0] out_word,
	output logic                    last_word,
	output logic                    result_kind,
	output logic             [31:0] blocks_produced,
	output logic             [31:0] blocks_discarded
);

	localparam int unsigned DEPTH = BASE_BLOCK_LEN + 1;

	logic [31:0] source_id_q;
	logic [15:0] rate_q;
	logic [15:0] magic_q;
	logic [7:0]  version_q;
	logic [7:0]  flag_mask_q;

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rd_data_q;

	logic [CW-1:0] fill_q;
	logic          long_q;
	logic [31:0]   last_seq_q;
	logic          have_last_q;
	logic          pending_q;
	logic [31:0]   block_no_q;
	logic [31:0]   produced_q;
	logic [31:0]   discarded_q;
	logic [31:0]   first_seq_q;
	logic [63:0]   first_time_q;
	logic [15:0]   dropped_q;
	logic [7:0]    flags_q;
	logic [31:0]   held_source_q;
	logic [15:0]   held_rate_q;

	req_t          req;
	logic [31:0]   diff;
	logic          gap_hit;
	logic [15:0]   gap;
	logic [CW-1:0] fill_eff;
	logic [CW-1:0] fill_next;
	logic          is_add;
	logic          drop;
	logic [31:0]   hdr_word;

	always_comb begin
		req       = req_t'(req_type);
		is_add    = (req == REQ_ADD);
		diff      = sample_seq - last_seq_q - 32'd1;
		gap_hit   = have_last_q && (diff != 32'd0);
		gap       = (diff[31:16] != 16'd0) ? GAP_MAX : diff[15:0];
		fill_eff  = gap_hit ? '0 : fill_q;
		fill_next = fill_eff + CW'(1);
		tgt_len   = CW'(BASE_BLOCK_LEN) + CW'(long_q);
		st.query  = (req == REQ_STATUS);
		st.full   = is_add && (fill_next == tgt_len);
		drop      = (req == REQ_SESSION) || (req == REQ_DISCARD) || (is_add && gap_hit);
		case (ctl.hdr_word)
			HW_MAGIC:    hdr_word = {flags_q, version_q, magic_q};
			HW_SOURCE:   hdr_word = held_source_q;
			HW_BLOCK_NO: hdr_word = block_no_q;
			HW_FIRST_SQ: hdr_word = first_seq_q;
			HW_TIME_LO:  hdr_word = first_time_q[31:0];
			HW_TIME_HI:  hdr_word = first_time_q[63:32];
			HW_RATE_LEN: hdr_word = {16'(tgt_len), held_rate_q};
			HW_DROPPED:  hdr_word = {16'(HEADER_BYTES), dropped_q};
			default:     hdr_word = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && is_add) begin
			mem_q[fill_eff[AW-1:0]] <= $unsigned(sample_value);
		end
		rd_data_q <= mem_q[rd_addr];
		if (ctl.accept && is_add && (fill_eff == '0)) begin
			flags_q       <= pending_q ? flag_mask_q : 8'd0;
			held_source_q <= source_id_q;
			held_rate_q   <= rate_q;
			first_seq_q   <= sample_seq;
			first_time_q  <= timestamp_ns;
			dropped_q     <= gap_hit ? gap : 16'd0;
		end
		if (ctl.load) begin
			last_word        <= ctl.last;
			result_kind      <= (ctl.src == SRC_STAT) ? KIND_STATUS : KIND_BLOCK;
			blocks_produced  <= (ctl.src == SRC_STAT) ? produced_q : 32'd0;
			blocks_discarded <= (ctl.src == SRC_STAT) ? discarded_q : 32'd0;
			case (ctl.src)
				SRC_HDR:  out_word <= hdr_word;
				SRC_DATA: out_word <= rd_data_q;
				default:  out_word <= 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_id_q <= '0;
			rate_q      <= '0;
			magic_q     <= '0;
			version_q   <= '0;
			flag_mask_q <= 8'd1;
			fill_q      <= '0;
			long_q      <= 1'b0;
			last_seq_q  <= '0;
			have_last_q <= 1'b0;
			pending_q   <= 1'b0;
			block_no_q  <= '0;
			produced_q  <= '0;
			discarded_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SOURCE_ID: source_id_q <= cfg_wdata;
					REG_RATE:      rate_q      <= cfg_wdata[15:0];
					REG_MAGIC:     magic_q     <= cfg_wdata[15:0];
					REG_VERSION:   version_q   <= cfg_wdata[7:0];
					REG_FLAG_MASK: flag_mask_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (ctl.accept) begin
				if (drop && (fill_q != '0)) begin
					discarded_q <= discarded_q + 32'd1;
				end
				case (req)
					REQ_ADD: begin
						fill_q      <= fill_next;
						last_seq_q  <= sample_seq;
						have_last_q <= 1'b1;
					end
					REQ_SESSION: begin
						fill_q      <= '0;
						have_last_q <= 1'b0;
						pending_q   <= 1'b1;
						long_q      <= 1'b0;
					end
					REQ_DISCARD: begin
						fill_q <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.finish) begin
				block_no_q <= block_no_q + 32'd1;
				produced_q <= produced_q + 32'd1;
				pending_q  <= 1'b0;
				fill_q     <= '0;
				long_q     <= !long_q;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sbf_checker.sv */
// Port-level checks on the sample block framer's word channel, and the bind
// that attaches them to the top level. No package dependency.
`default_nettype none
module sbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [31:0] out_word,
	input wire logic        last_word,
	input wire logic        result_kind,
	input wire logic [31:0] blocks_produced,
	input wire logic [31:0] blocks_discarded
);

	// A status answer is a single, closing word with no data.
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind |-> last_word && (out_word == 32'd0))
		else $error("status answer is malformed");

	// Block words never carry the counters.
	a_block_counts: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result_kind |-> (blocks_produced == 32'd0) && (blocks_discarded == 32'd0))
		else $error("block word carries counters");

	// A stalled word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_word) && $stable(last_word)
			&& $stable(result_kind))
		else $error("stalled word changed");

endmodule

bind sample_block_framer sbf_checker u_sbf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.valid            (words.valid),
	.ready            (words.ready),
	.out_word         (words.out_word),
	.last_word        (words.last_word),
	.result_kind      (words.result_kind),
	.blocks_produced  (words.blocks_produced),
	.blocks_discarded (words.blocks_discarded)
);
`default_nettype wire

/* test/sample_block_framer_tb.sv */
// Self-checking testbench for sample_block_framer: random and directed request items,
// with the block words and status answers checked against a scoreboard model.
// Depends on sbf_pkg, sbf_if and the sample_block_framer RTL.
module sample_block_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbf_pkg::*;

	localparam int BLOCK_LEN = 32;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 120;
	localparam logic [2:0] REG_SPARE = 3'd5;

	typedef struct packed {
		req_t        kind;
		logic [31:0] value;
		logic [31:0] seq;
		logic [63:0] stamp;
	} framer_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        kind;
		logic [31:0] produced;
		logic [31:0] discarded;
	} block_word_t;

	class block_word_scoreboard;
		block_word_t expected_words[$];
		int mismatches = 0;

		logic [31:0] source_id = '0;
		logic [15:0] rate = '0;
		logic [15:0] magic = '0;
		logic [7:0]  version = '0;
		logic [7:0]  flag_mask = 8'h01;

		logic [31:0] store [BLOCK_LEN + 1];
		int unsigned fill = 0;
		bit          long_next = 0;
		bit          have_last = 0;
		bit          session_pending = 0;
		logic [31:0] last_seq = '0;
		logic [31:0] block_no = '0;
		logic [31:0] produced = '0;
		logic [31:0] discarded = '0;
		logic [31:0] first_seq = '0;
		logic [63:0] first_stamp = '0;
		logic [15:0] dropped = '0;
		logic [7:0]  flags = '0;
		logic [31:0] held_source = '0;
		logic [15:0] held_rate = '0;

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
			REG_SOURCE_ID: source_id = data;
			REG_RATE:      rate = data[15:0];
			REG_MAGIC:     magic = data[15:0];
			REG_VERSION:   version = data[7:0];
			REG_FLAG_MASK: flag_mask = data[7:0];
			default: ;
			endcase
		endfunction

		function void drop_partial();
			if (fill != 0)
				discarded = discarded + 32'd1;
			fill = 0;
		endfunction

		function void push_word(logic [31:0] word, logic last, logic kind,
				logic [31:0] prod, logic [31:0] disc);
			block_word_t w;
			w = '{word, last, kind, prod, disc};
			expected_words.push_back(w);
		endfunction

		function void note_item(framer_item_t it);
			logic [31:0] gap_raw;
			logic [15:0] gap;
			logic [31:0] hdr [8];
			int unsigned target;
			case (it.kind)
			REQ_SESSION: begin
				drop_partial();
				have_last = 0;
				session_pending = 1;
				long_next = 0;
				return;
			end
			REQ_DISCARD: begin
				drop_partial();
				return;
			end
			REQ_STATUS: begin
				push_word(32'd0, 1'b1, KIND_STATUS, produced, discarded);
				return;
			end
			default: ;
			endcase

			gap = '0;
			if (have_last && it.seq != last_seq + 32'd1) begin
				gap_raw = it.seq - last_seq - 32'd1;
				gap = (gap_raw > 32'h0000_ffff) ? GAP_MAX : gap_raw[15:0];
				drop_partial();
			end
			if (fill == 0) begin
				flags = session_pending ? flag_mask : 8'h00;
				held_source = source_id;
				held_rate = rate;
				first_seq = it.seq;
				first_stamp = it.stamp;
				dropped = gap;
			end
			store[fill] = it.value;
			fill++;
			last_seq = it.seq;
			have_last = 1;

			target = BLOCK_LEN + (long_next ? 1 : 0);
			if (fill < target)
				return;

			hdr[HW_MAGIC]    = {flags, version, magic};
			hdr[HW_SOURCE]   = held_source;
			hdr[HW_BLOCK_NO] = block_no;
			hdr[HW_FIRST_SQ] = first_seq;
			hdr[HW_TIME_LO]  = first_stamp[31:0];
			hdr[HW_TIME_HI]  = first_stamp[63:32];
			hdr[HW_RATE_LEN] = {16'(target), held_rate};
			hdr[HW_DROPPED]  = {16'(HEADER_BYTES), dropped};
			for (int i = 0; i < 8; i++)
				push_word(hdr[i], 1'b0, KIND_BLOCK, '0, '0);
			for (int unsigned i = 0; i < target; i++)
				push_word(store[i], i + 1 == target, KIND_BLOCK, '0, '0);

			block_no = block_no + 32'd1;
			produced = produced + 32'd1;
			session_pending = 0;
			fill = 0;
			long_next = !long_next;
		endfunction

		function void check_word(block_word_t got);
			block_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word %h last %b kind %b produced %0d discarded %0d",
						got.word, got.last, got.kind, got.produced, got.discarded);
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Word mismatch: expected %h/%b/%b/%0d/%0d, got %h/%b/%b/%0d/%0d",
						want.word, want.last, want.kind, want.produced, want.discarded,
						got.word, got.last, got.kind, got.produced, got.discarded);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic [31:0] seq_next;

	block_word_scoreboard board = new();

	sbf_item_if items();
	sbf_word_if words();

	sample_block_framer #(
		.BASE_BLOCK_LEN(BLOCK_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.items(items),
		.words(words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		words.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && words.valid && words.ready)
			board.check_word(block_word_t'{words.out_word, words.last_word, words.result_kind,
				words.blocks_produced, words.blocks_discarded});
	end

	task automatic send_item(req_t kind, logic [31:0] value, logic [31:0] seq,
			logic [63:0] stamp);
		framer_item_t it;
		it = '{kind, value, seq, stamp};
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.req_type <= kind;
		items.sample_value <= value;
		items.sample_seq <= seq;
		items.timestamp_ns <= stamp;
		do @(posedge clk); while (!items.ready);
		board.note_item(it);
	endtask

	task automatic send_sample(logic [31:0] seq);
		send_item(REQ_ADD, $urandom, seq, {$urandom, $urandom});
		seq_next = seq + 32'd1;
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic write_config(logic [31:0] source, logic [31:0] rate, logic [31:0] magic,
			logic [31:0] version, logic [31:0] mask);
		set_reg(REG_SOURCE_ID, source);
		set_reg(REG_RATE, rate);
		set_reg(REG_MAGIC, magic);
		set_reg(REG_VERSION, version);
		set_reg(REG_FLAG_MASK, mask);
		set_reg(REG_SPARE + 3'($urandom_range(2)), $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count);
		int  sent;
		int  run_len;
		bit  paused;
		sent = 0;
		paused = 0;
		while (sent < count) begin
			run_len = $urandom_range(75, 20);
			for (int i = 0; i < run_len && sent < count; i++) begin
				if ($urandom_range(99) < 4)
					send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
				else
					send_sample(seq_next);
				sent++;
				if (!paused && 2 * sent >= count && board.pending() != 0) begin
					drain();
					paused = 1;
				end
			end
			case ($urandom_range(5))
			0: send_item(REQ_SESSION, $urandom, $urandom, {$urandom, $urandom});
			1: send_item(REQ_DISCARD, $urandom, $urandom, {$urandom, $urandom});
			2: send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
			3: send_sample(seq_next + 32'($urandom_range(40, 1)));
			4: send_sample(seq_next - 32'($urandom_range(2, 1)));
			default: send_sample($urandom);
			endcase
			sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		items.valid = 1'b0;
		items.req_type = REQ_ADD;
		items.sample_value = '0;
		items.sample_seq = '0;
		items.timestamp_ns = '0;
		words.ready = 1'b0;
		seq_next = '0;
		send_idle_pct = 17;
		recv_idle_pct = 59;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config('1, '1, '1, '1, '1);
		send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_DISCARD, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_ADD, 32'h7fff_ffff, 32'hffff_ffff, 64'd0);
		send_item(REQ_ADD, 32'h8000_0000, 32'd0, '1);
		send_item(REQ_ADD, 32'd0, 32'd1, 64'h8000_0000_0000_0000);
		// A gap of one sample drops the three samples held so far.
		send_item(REQ_ADD, 32'hffff_ffff, 32'd3, {$urandom, $urandom});
		send_item(REQ_ADD, 32'd1, 32'd4, {$urandom, $urandom});
		send_item(REQ_DISCARD, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_DISCARD, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd5, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd65541, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd65542, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd131079, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd131079, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'd131078, {$urandom, $urandom});
		send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_SESSION, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_SESSION, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'h1234_5678, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'h1234_5679, {$urandom, $urandom});
		send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
		send_item(REQ_ADD, $urandom, 32'h1234_567c, {$urandom, $urandom});
		send_item(REQ_STATUS, $urandom, $urandom, {$urandom, $urandom});
		seq_next = 32'h1234_567d;
		run_random(RANDOM_ITEMS);
		drain();

		send_idle_pct = 59;
		recv_idle_pct = 17;
		write_config($urandom, $urandom, $urandom, $urandom, $urandom);
		run_random(RANDOM_ITEMS);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_config('0, '0, '0, '0, '0);
		run_random(RANDOM_ITEMS);
		drain();

		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* filelist.f */
rtl/sbf_pkg.sv
rtl/sbf_if.sv
rtl/sbf_ctrl.sv
rtl/sbf_dp.sv
rtl/sample_block_framer.sv
rtl/sbf_checker.sv
test/sample_block_framer_tb.sv
